/* hdl/cbps_pkg.sv */
package cbps_pkg;

  // Field and arithmetic widths
  localparam int COORD_W     = 16;
  localparam int T_FRAC      = 16;
  localparam int MAX_SAMPLES = 64;
  localparam int CNT_W       = $clog2(MAX_SAMPLES);
  localparam int NUM_PTS     = 8;
  localparam int PT_IDX_W    = $clog2(NUM_PTS);

  localparam int U_W    = T_FRAC + 1;            // u = 1 - t, can be exactly one
  localparam int SQ_W   = 2 * T_FRAC + 1;        // u*u, t*t
  localparam int W_W    = 3 * T_FRAC + 1;        // cubic weights
  localparam int B_W    = (COORD_W + 2 > U_W) ? COORD_W + 2 : U_W;
  localparam int A_W    = W_W;
  localparam int PROD_W = A_W + B_W;
  localparam int ACC_W  = 3 * T_FRAC + COORD_W + 2;
  localparam int SHIFT  = 3 * T_FRAC;

  localparam logic [ACC_W-1:0]   ACC_HALF  = ACC_W'(1) << (SHIFT - 1);
  localparam logic [COORD_W-1:0] COORD_SGN = COORD_W'(1) << (COORD_W - 1);
  localparam logic [T_FRAC-1:0]  STEP_RST  = T_FRAC'(4096);

  localparam int IN_DATA_W  = ((NUM_PTS * COORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_W + 7) / 8) * 8;

  // Microprogram
  localparam int NUM_STEPS = 18;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_LOOP = STEP_W'(1);

  typedef enum logic [2:0] {
    A_U, A_UU, A_TT, A_W0, A_W1, A_W2, A_W3, A_T
  } a_sel_e;

  typedef enum logic [1:0] {
    B_U, B_T, B_PT
  } b_sel_e;

  typedef enum logic [2:0] {
    D_NONE, D_PROD, D_UU, D_TT, D_W0, D_W1, D_W2, D_W3
  } dest_e;

  typedef enum logic [1:0] {
    ACC_NOP, ACC_LOAD, ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_WAIT_IN, SEQ_EMIT
  } seq_e;

  typedef struct packed {
    a_sel_e                a_sel;
    b_sel_e                b_sel;
    logic [PT_IDX_W-1:0]   pt_idx;
    logic                  triple;
    dest_e                 dest;
    acc_op_e               acc_op;
    logic                  cap_x;
    seq_e                  seq;
  } uword_t;

  function automatic uword_t mk(a_sel_e a, b_sel_e b, logic [PT_IDX_W-1:0] idx,
                                logic tri3, dest_e d, acc_op_e op, logic cx,
                                seq_e sq);
    uword_t w;
    w.a_sel  = a;
    w.b_sel  = b;
    w.pt_idx = idx;
    w.triple = tri3;
    w.dest   = d;
    w.acc_op = op;
    w.cap_x  = cx;
    w.seq    = sq;
    return w;
  endfunction

  // Control store. Points are stored x0,y0,x1,y1,... so x of Pi sits at 2i.
  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      5'd0:    w = mk(A_U,  B_U,  3'd0, 1'b0, D_NONE, ACC_NOP,  1'b0, SEQ_WAIT_IN);
      5'd1:    w = mk(A_U,  B_U,  3'd0, 1'b0, D_UU,   ACC_NOP,  1'b0, SEQ_NEXT);
      5'd2:    w = mk(A_T,  B_T,  3'd0, 1'b0, D_TT,   ACC_NOP,  1'b0, SEQ_NEXT);
      5'd3:    w = mk(A_UU, B_U,  3'd0, 1'b0, D_W0,   ACC_NOP,  1'b0, SEQ_NEXT);
      5'd4:    w = mk(A_UU, B_T,  3'd0, 1'b0, D_W1,   ACC_NOP,  1'b0, SEQ_NEXT);
      5'd5:    w = mk(A_TT, B_U,  3'd0, 1'b0, D_W2,   ACC_NOP,  1'b0, SEQ_NEXT);
      5'd6:    w = mk(A_TT, B_T,  3'd0, 1'b0, D_W3,   ACC_NOP,  1'b0, SEQ_NEXT);
      5'd7:    w = mk(A_W0, B_PT, 3'd0, 1'b0, D_PROD, ACC_NOP,  1'b0, SEQ_NEXT);
      5'd8:    w = mk(A_W1, B_PT, 3'd2, 1'b1, D_PROD, ACC_LOAD, 1'b0, SEQ_NEXT);
      5'd9:    w = mk(A_W2, B_PT, 3'd4, 1'b1, D_PROD, ACC_ADD,  1'b0, SEQ_NEXT);
      5'd10:   w = mk(A_W3, B_PT, 3'd6, 1'b0, D_PROD, ACC_ADD,  1'b0, SEQ_NEXT);
      5'd11:   w = mk(A_U,  B_U,  3'd0, 1'b0, D_NONE, ACC_ADD,  1'b0, SEQ_NEXT);
      5'd12:   w = mk(A_W0, B_PT, 3'd1, 1'b0, D_PROD, ACC_NOP,  1'b1, SEQ_NEXT);
      5'd13:   w = mk(A_W1, B_PT, 3'd3, 1'b1, D_PROD, ACC_LOAD, 1'b0, SEQ_NEXT);
      5'd14:   w = mk(A_W2, B_PT, 3'd5, 1'b1, D_PROD, ACC_ADD,  1'b0, SEQ_NEXT);
      5'd15:   w = mk(A_W3, B_PT, 3'd7, 1'b0, D_PROD, ACC_ADD,  1'b0, SEQ_NEXT);
      5'd16:   w = mk(A_U,  B_U,  3'd0, 1'b0, D_NONE, ACC_ADD,  1'b0, SEQ_NEXT);
      5'd17:   w = mk(A_U,  B_U,  3'd0, 1'b0, D_NONE, ACC_NOP,  1'b0, SEQ_EMIT);
      default: w = mk(A_U,  B_U,  3'd0, 1'b0, D_NONE, ACC_NOP,  1'b0, SEQ_WAIT_IN);
    endcase
    return w;
  endfunction

endpackage

/* hdl/cubic_bezier_point_sampler.sv */
// Cubic Bezier sampler, microcoded around one 49x18 multiplier and one accumulator.
// Each sample computes the weights u^3, 3u^2t, 3ut^2, t^3, then four
// multiply-accumulates per coordinate.
// A stalled output holds the program.
// Reset (async, active low) clears the sequencer and output valid; t_step resets to 1/16.
module cubic_bezier_point_sampler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write channel: t_step
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cbps_pkg::T_FRAC-1:0]       cfg_data_i,
  // input curve
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y (low bits first)
  input  logic [cbps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // output samples
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // point_x, point_y (low bits first)
  output logic [cbps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast
);

  // Sequencer and control state
  logic [cbps_pkg::STEP_W-1:0]  step_q, step_d;
  logic [cbps_pkg::T_FRAC-1:0]  t_step_q;
  logic [cbps_pkg::T_FRAC-1:0]  t_q;
  logic [cbps_pkg::CNT_W-1:0]   n_q;
  logic                         m_valid_q;

  // Datapath registers
  logic [cbps_pkg::COORD_W-1:0] pt_q [cbps_pkg::NUM_PTS];
  logic [cbps_pkg::SQ_W-1:0]    uu_q, tt_q;
  logic [cbps_pkg::W_W-1:0]     w0_q, w1_q, w2_q, w3_q;
  logic [cbps_pkg::ACC_W-1:0]   prod_q, acc_q;
  logic [cbps_pkg::COORD_W-1:0] px_q;
  logic [cbps_pkg::COORD_W-1:0] out_x_q, out_y_q;
  logic                         out_last_q;

  cbps_pkg::uword_t             uw;
  logic [cbps_pkg::U_W-1:0]     u;
  logic [cbps_pkg::U_W-1:0]     t_next;
  logic                         is_last;
  logic                         in_fire, emit_go;
  logic [cbps_pkg::A_W-1:0]     a_val;
  logic [cbps_pkg::B_W-1:0]     b_val;
  logic [cbps_pkg::COORD_W-1:0] pt_sel;
  logic [cbps_pkg::PROD_W-1:0]  prod_full;
  logic [cbps_pkg::COORD_W-1:0] acc_coord;

  assign uw = cbps_pkg::ucode(step_q);

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (uw.seq == cbps_pkg::SEQ_WAIT_IN);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign emit_go       = (uw.seq == cbps_pkg::SEQ_EMIT) && (!m_valid_q || m_axis_tready);

  // u = 1 - t, next t and last-sample test
  assign u       = (cbps_pkg::U_W'(1) << cbps_pkg::T_FRAC) - cbps_pkg::U_W'(t_q);
  assign t_next  = cbps_pkg::U_W'(t_q) + cbps_pkg::U_W'(t_step_q);
  assign is_last = t_next[cbps_pkg::T_FRAC] ||
                   (n_q == cbps_pkg::CNT_W'(cbps_pkg::MAX_SAMPLES - 1));

  // Operand selection
  assign pt_sel = pt_q[uw.pt_idx];

  always_comb begin
    case (uw.a_sel)
      cbps_pkg::A_U:  a_val = cbps_pkg::A_W'(u);
      cbps_pkg::A_T:  a_val = cbps_pkg::A_W'(t_q);
      cbps_pkg::A_UU: a_val = cbps_pkg::A_W'(uu_q);
      cbps_pkg::A_TT: a_val = cbps_pkg::A_W'(tt_q);
      cbps_pkg::A_W0: a_val = w0_q;
      cbps_pkg::A_W1: a_val = w1_q;
      cbps_pkg::A_W2: a_val = w2_q;
      cbps_pkg::A_W3: a_val = w3_q;
      default:        a_val = '0;
    endcase
  end

  always_comb begin
    case (uw.b_sel)
      cbps_pkg::B_U: b_val = cbps_pkg::B_W'(u);
      cbps_pkg::B_T: b_val = cbps_pkg::B_W'(t_q);
      cbps_pkg::B_PT: begin
        if (uw.triple) begin
          b_val = cbps_pkg::B_W'(pt_sel) + (cbps_pkg::B_W'(pt_sel) << 1);
        end else begin
          b_val = cbps_pkg::B_W'(pt_sel);
        end
      end
      default: b_val = '0;
    endcase
  end

  assign prod_full = cbps_pkg::PROD_W'(a_val) * cbps_pkg::PROD_W'(b_val);

  // Rounded coordinate back from offset binary (half already added on load)
  assign acc_coord = acc_q[cbps_pkg::SHIFT +: cbps_pkg::COORD_W] ^ cbps_pkg::COORD_SGN;

  // Step counter with conditional jumps
  always_comb begin
    step_d = step_q;
    case (uw.seq)
      cbps_pkg::SEQ_WAIT_IN: if (in_fire) step_d = cbps_pkg::STEP_LOOP;
      cbps_pkg::SEQ_EMIT: begin
        if (emit_go) step_d = is_last ? cbps_pkg::STEP_IDLE : cbps_pkg::STEP_LOOP;
      end
      cbps_pkg::SEQ_NEXT: step_d = step_q + cbps_pkg::STEP_W'(1);
      default: step_d = cbps_pkg::STEP_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= cbps_pkg::STEP_IDLE;
      t_step_q  <= cbps_pkg::STEP_RST;
      t_q       <= '0;
      n_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (cfg_valid_i && cfg_ready_o) t_step_q <= cfg_data_i;
      if (in_fire) begin
        t_q <= '0;
        n_q <= '0;
      end else if (emit_go && !is_last) begin
        t_q <= t_next[cbps_pkg::T_FRAC-1:0];
        n_q <= n_q + cbps_pkg::CNT_W'(1);
      end
      if (emit_go) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    // control points kept in offset binary
    if (in_fire) begin
      for (int i = 0; i < cbps_pkg::NUM_PTS; i++) begin
        pt_q[i] <= s_axis_tdata[i*cbps_pkg::COORD_W +: cbps_pkg::COORD_W] ^ cbps_pkg::COORD_SGN;
      end
    end
    // multiplier writeback
    case (uw.dest)
      cbps_pkg::D_PROD: prod_q <= prod_full[cbps_pkg::ACC_W-1:0];
      cbps_pkg::D_UU:   uu_q   <= prod_full[cbps_pkg::SQ_W-1:0];
      cbps_pkg::D_TT:   tt_q   <= prod_full[cbps_pkg::SQ_W-1:0];
      cbps_pkg::D_W0:   w0_q   <= prod_full[cbps_pkg::W_W-1:0];
      cbps_pkg::D_W1:   w1_q   <= prod_full[cbps_pkg::W_W-1:0];
      cbps_pkg::D_W2:   w2_q   <= prod_full[cbps_pkg::W_W-1:0];
      cbps_pkg::D_W3:   w3_q   <= prod_full[cbps_pkg::W_W-1:0];
      default: ;
    endcase
    // accumulator
    case (uw.acc_op)
      cbps_pkg::ACC_LOAD: acc_q <= prod_q + cbps_pkg::ACC_HALF;
      cbps_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
      default: ;
    endcase
    if (uw.cap_x) px_q <= acc_coord;
    // output register
    if (emit_go) begin
      out_x_q    <= px_q;
      out_y_q    <= acc_coord;
      out_last_q <= is_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = cbps_pkg::OUT_DATA_W'({out_y_q, out_x_q});
  assign m_axis_tlast  = out_last_q;

  // Checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> step_q == cbps_pkg::STEP_LOOP)
    else $error("program did not start after input beat");

  a_max_samples_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && n_q == cbps_pkg::CNT_W'(cbps_pkg::MAX_SAMPLES - 1)) |=> m_axis_tlast)
    else $error("sample limit reached without last flag");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(uw.seq == cbps_pkg::SEQ_EMIT))
    else $error("output beat raised outside emit step");

endmodule

/* bench/testbench.sv */
module testbench;

  typedef logic [cbps_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } curve_point_t;

  localparam logic [cbps_pkg::T_FRAC:0] T_ONE =
    (cbps_pkg::T_FRAC+1)'(1) << cbps_pkg::T_FRAC;
  localparam int              CYCLE_LIMIT = 3_000_000;
  localparam int              SHOWN_MAX   = 10;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [cbps_pkg::T_FRAC-1:0]     cfg_data_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [cbps_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [cbps_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;

  // predictor state and run bookkeeping
  logic [cbps_pkg::T_FRAC-1:0] step_setting = cbps_pkg::STEP_RST;
  curve_point_t      expected_points[$];
  int                mismatches   = 0;
  int                curves_sent  = 0;
  int                points_seen  = 0;
  int                step_writes  = 0;
  int                cycle_count  = 0;
  bit                steady_flow  = 1'b0;

  cubic_bezier_point_sampler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10-unit clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones; none while steady_flow is set
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // corner-biased coordinate
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Exact Bernstein sum in offset binary, rounded half up, back to two's complement
  function automatic coord_t bezier_coord(coord_t p0, coord_t p1, coord_t p2, coord_t p3,
                                          logic [cbps_pkg::T_FRAC:0] t);
    logic [79:0] u;
    logic [79:0] tw;
    logic [79:0] acc;
    u   = 80'(T_ONE - t);
    tw  = 80'(t);
    acc = 80'(p0 ^ cbps_pkg::COORD_SGN) * u * u * u
        + 80'(p1 ^ cbps_pkg::COORD_SGN) * 3 * u * u * tw
        + 80'(p2 ^ cbps_pkg::COORD_SGN) * 3 * u * tw * tw
        + 80'(p3 ^ cbps_pkg::COORD_SGN) * tw * tw * tw;
    acc = acc + (80'(1) << (3 * cbps_pkg::T_FRAC - 1));
    return coord_t'(acc >> (3 * cbps_pkg::T_FRAC)) ^ cbps_pkg::COORD_SGN;
  endfunction

  // Queue every sample point one curve beat produces under the current step
  task automatic predict_samples(input logic [cbps_pkg::IN_DATA_W-1:0] beat);
    coord_t                      px[4];
    coord_t                      py[4];
    logic [cbps_pkg::T_FRAC:0]   t;
    logic [cbps_pkg::T_FRAC+1:0] t_next;
    curve_point_t                pt;
    int                          n;
    bit                          done;
    for (int i = 0; i < 4; i++) begin
      px[i] = beat[(2*i)*cbps_pkg::COORD_W +: cbps_pkg::COORD_W];
      py[i] = beat[(2*i+1)*cbps_pkg::COORD_W +: cbps_pkg::COORD_W];
    end
    t    = '0;
    n    = 0;
    done = 1'b0;
    while (!done) begin
      t_next  = t + step_setting;
      pt.last = (t_next >= T_ONE) || (n + 1 >= cbps_pkg::MAX_SAMPLES);
      pt.x    = bezier_coord(px[0], px[1], px[2], px[3], t);
      pt.y    = bezier_coord(py[0], py[1], py[2], py[3], t);
      expected_points.push_back(pt);
      n++;
      done = pt.last;
      t    = t_next[cbps_pkg::T_FRAC:0];
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= SHOWN_MAX) $display("%s", msg);
  endtask

  // Watch both handshakes on the rising edge; check each output beat
  always @(posedge clk_i) begin
    curve_point_t got;
    curve_point_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) step_setting = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) predict_samples(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.x    = m_axis_tdata[cbps_pkg::COORD_W-1:0];
        got.y    = m_axis_tdata[2*cbps_pkg::COORD_W-1:cbps_pkg::COORD_W];
        got.last = m_axis_tlast;
        points_seen++;
        if (expected_points.size() == 0) begin
          note_mismatch($sformatf("unexpected point x=%0d y=%0d last=%0b",
                                  $signed(got.x), $signed(got.y), got.last));
        end else begin
          want = expected_points.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.last !== want.last)
            note_mismatch($sformatf(
              "point %0d: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
              points_seen, $signed(want.x), $signed(want.y), want.last,
              $signed(got.x), $signed(got.y), got.last));
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cubic_bezier_point_sampler verification failed");
      $finish;
    end
  end

  // Output side backpressure
  initial begin
    int run;
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      run = $urandom_range(1, 30);
      repeat (run) begin
        @(negedge clk_i);
        m_axis_tready = 1'b1;
      end
      gap = pick_gap();
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
    end
  end

  // One curve beat, after a random gap; valid stays high if no gap follows
  task automatic send_curve(input coord_t sx, sy, c1x, c1y, c2x, c2y, ex, ey);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {ey, ex, c2y, c2x, c1y, c1x, sy, sx};
    do @(posedge clk_i); while (!s_axis_tready);
    curves_sent++;
  endtask

  task automatic send_random_curve();
    send_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Stop the input stream and wait for every pending point
  task automatic settle_curves();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
  endtask

  // Step register write, only with the block idle
  task automatic set_step(input logic [cbps_pkg::T_FRAC-1:0] value);
    settle_curves();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    step_writes++;
  endtask

  // Reset step of 1/16 with coordinate extremes
  task automatic test_reset_step_extremes();
    send_curve(16'h8000, 16'h8000, 16'h8000, 16'h8000,
               16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_curve(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
               16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_curve('0, '0, '0, '0, '0, '0, '0, '0);
    send_curve(16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
               16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
    send_curve(16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
               16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    settle_curves();
  endtask

  // Largest steps: two samples per curve; at t = 1/2 exact halves round up
  task automatic test_coarse_steps();
    set_step(16'hffff);
    send_curve(16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
               16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_random_curve();
    set_step(16'h8000);
    send_curve('0, '0, '0, '0, '0, '0, 16'd4, -16'sd4);
    send_curve('0, '0, '0, '0, '0, '0, -16'sd12, 16'd12);
    send_random_curve();
    settle_curves();
  endtask

  // Smallest steps: 1/64, below 1/64, one LSB and zero all stop at the sample cap
  task automatic test_fine_steps();
    set_step(16'd1024);
    send_curve(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
               16'h8000, 16'h8000, 16'h7fff, 16'h8000);
    set_step(16'd1000);
    send_random_curve();
    set_step(16'd1);
    send_random_curve();
    set_step(16'd0);
    send_random_curve();
    settle_curves();
  endtask

  // Random curves across several step settings
  task automatic test_random_curves();
    int steps[8];
    int step_val;
    steps = '{4096, 1025, 65535, 21846, 9000, 2048, -1, -1};
    for (int p = 0; p < 8; p++) begin
      step_val = (steps[p] < 0) ? $urandom_range(1024, 65535) : steps[p];
      set_step(cbps_pkg::T_FRAC'(step_val));
      steady_flow = (p == 3);
      for (int i = 0; i < 20; i++) begin
        // hold the sender until the block has drained
        if (p == 4 && i == 10) settle_curves();
        send_random_curve();
      end
    end
    steady_flow = 1'b0;
    settle_curves();
  endtask

  // Test sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_step_extremes();
    test_coarse_steps();
    test_fine_steps();
    test_random_curves();

    settle_curves();
    repeat (40) @(posedge clk_i);
    mismatches += expected_points.size();

    $display("Sent %0d curves under %0d step writes, checked %0d sample points.",
             curves_sent, step_writes, points_seen);
    $display("Steps ranged from zero to full scale, incl. half-point rounding ties.");
    if (mismatches == 0) begin
      $display("cubic_bezier_point_sampler verification clean");
    end else begin
      $display("cubic_bezier_point_sampler verification failed");
    end
    $finish;
  end

endmodule
